>>> hdl/crse_pkg.sv
// shared types and codes for the catmull-rom spline evaluator
// no dependencies; used by every module of the block
package crse_pkg;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  typedef enum logic {
    ST_OK  = 1'b0,
    ST_ERR = 1'b1
  } status_t;

  typedef struct packed {
    logic        action;
    logic [5:0]  index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [16:0] frac;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        status;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic acc_en;
    logic acc_clr;
  } mac_ctl_t;

  localparam int unsigned CFG_W  = 7;
  localparam int unsigned PROD_W = 50;
  localparam int unsigned ACC_W  = 52;
  localparam int unsigned ONE_Q16 = 65536;

endpackage

>>> hdl/crse_point_mem.sv
// control point memory: one write port, one read port, registered read data
// depends on crse_pkg for the point type
module crse_point_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  crse_pkg::point_t wdata,
  input  logic [AW-1:0]   raddr,
  output crse_pkg::point_t rdata
);

  crse_pkg::point_t mem [DEPTH];
  crse_pkg::point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/crse_mac.sv
// shared signed 18x32 multiplier with registered product and accumulator
// depends on crse_pkg for widths and the control struct
module crse_mac (
  input  logic                               clk,
  input  logic signed [17:0]                 op_a,
  input  logic signed [31:0]                 op_b,
  input  crse_pkg::mac_ctl_t                 ctl,
  output logic signed [crse_pkg::PROD_W-1:0] prod,
  output logic signed [crse_pkg::ACC_W-1:0]  acc
);

  logic signed [crse_pkg::PROD_W-1:0] prod_r;
  logic signed [crse_pkg::ACC_W-1:0]  acc_r;
  logic signed [crse_pkg::ACC_W-1:0]  acc_nxt;

  assign acc_nxt = (ctl.acc_clr ? '0 : acc_r) + crse_pkg::ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl.acc_en) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

>>> hdl/catmull_rom_spline_evaluator_unit.sv
// catmull-rom spline evaluator: a write item's result strobe comes the cycle after accept;
// errors likewise. an evaluation at an endpoint or zero/full fraction passes through state
// S_RAW, then strobes. an interpolated evaluation: 8 point reads, one per cycle, then 14 passes
// through one 18x32 multiplier, then the strobe. busy holds during that; one item at a time,
// next item accepted in the strobe cycle. results cannot be stalled.
// reset (rst_n, synchronous) clears control and num_points; the point memory is not cleared.
module catmull_rom_spline_evaluator_unit #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  crse_pkg::in_item_t  in_data,
  output logic                out_valid,
  output crse_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [crse_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned AW  = $clog2(MAX_POINTS);
  localparam int unsigned NW0 = $clog2(MAX_POINTS + 1);
  localparam int unsigned WW  = (NW0 > crse_pkg::CFG_W) ? NW0 : crse_pkg::CFG_W;
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned SW = $clog2(NUM_SLOTS);
  localparam logic [4:0] ST_MUL0  = 5'd4;
  localparam logic [4:0] ST_ACC0  = 5'd5;
  localparam logic [4:0] ST_ACC_L = 5'd16;
  localparam logic [4:0] ST_X     = 5'd9;
  localparam logic [4:0] ST_Y     = 5'd13;
  localparam logic [4:0] ST_LAST  = 5'd17;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RAW,
    S_RD,
    S_CALC
  } state_t;

  state_t              state_r;
  logic [SW-1:0]       cnt_r;
  logic [4:0]          step_r;
  logic                out_valid_r;
  logic                out_valid_nxt;
  crse_pkg::out_item_t out_data_r;
  logic [crse_pkg::CFG_W-1:0] num_points_r;

  logic [WW-1:0]       idx_r;
  logic [WW-1:0]       n_r;
  logic [16:0]         t_r;
  logic [16:0]         t2_r;
  logic [16:0]         t3_r;
  logic                closed_r;
  logic                rd_vld_r;
  logic [SW-1:0]       rd_slot_r;
  crse_pkg::point_t    p_r [NUM_SLOTS];
  logic signed [31:0]  m0_r [3];
  logic signed [31:0]  m1_r [3];
  logic signed [17:0]  h_r [4];
  logic signed [31:0]  px_r;
  logic signed [31:0]  py_r;

  logic                accept;
  logic [WW-1:0]       idx_w;
  logic [WW-1:0]       n_w;
  logic [WW-1:0]       cfg_n_w;
  logic                mem_we;
  logic [AW-1:0]       raddr;
  logic [WW-1:0]       slot_addr;
  crse_pkg::point_t    rdata;
  crse_pkg::point_t    wpoint;
  logic signed [17:0]  op_a;
  logic signed [31:0]  op_b;
  crse_pkg::mac_ctl_t  mac_ctl;
  logic signed [crse_pkg::PROD_W-1:0] prod;
  logic signed [crse_pkg::ACC_W-1:0]  acc;
  logic signed [crse_pkg::ACC_W-1:0]  acc_adj;
  logic signed [crse_pkg::ACC_W-1:0]  quo;
  logic signed [31:0]  fin;
  logic [4:0]          mj;
  logic [4:0]          aj;
  logic signed [19:0]  t1s, t2s, t3s;
  logic signed [19:0]  h00, h01, h10, h11;
  logic                first_pt;
  logic                last_seg;

  function automatic logic signed [31:0] axis_of(crse_pkg::point_t p, logic [1:0] a);
    logic signed [31:0] v;
    unique case (a)
      2'd0:    v = p.x;
      2'd1:    v = p.y;
      default: v = p.z;
    endcase
    return v;
  endfunction

  // (a - b) / 2, truncated toward zero
  function automatic logic signed [31:0] half_diff(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [32:0] h;
    d = 33'(a) - 33'(b);
    h = (d + 33'(d[32])) >>> 1;
    return h[31:0];
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx_w   = WW'(in_data.index);
  assign cfg_n_w = WW'(num_points_r);
  assign n_w     = (cfg_n_w > WW'(MAX_POINTS)) ? WW'(MAX_POINTS) : cfg_n_w;
  assign mem_we  = accept && (in_data.action == crse_pkg::ACT_WRITE)
                && (idx_w < WW'(MAX_POINTS));
  assign wpoint  = '{x: in_data.point_x, y: in_data.point_y, z: in_data.point_z};

  // read slots: P[i-1], P[i], P[i+1], P[i+2], P[0], P[n-1], P[1], P[n-2]
  always_comb begin
    unique case (cnt_r)
      3'd0:    slot_addr = idx_r - WW'(1);
      3'd1:    slot_addr = idx_r;
      3'd2:    slot_addr = idx_r + WW'(1);
      3'd3:    slot_addr = idx_r + WW'(2);
      3'd4:    slot_addr = '0;
      3'd5:    slot_addr = n_r - WW'(1);
      3'd6:    slot_addr = WW'(1);
      default: slot_addr = n_r - WW'(2);
    endcase
  end

  always_comb begin
    if (state_r == S_RD) begin
      raddr = slot_addr[AW-1:0];
    end else if (in_data.frac[16] && (idx_w + WW'(1) != n_w)) begin
      raddr = AW'(idx_w + WW'(1));
    end else begin
      raddr = AW'(idx_w);
    end
  end

  crse_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(idx_w)),
    .wdata (wpoint),
    .raddr (raddr),
    .rdata (rdata)
  );

  // hermite basis in signed q1.16
  assign t1s = signed'(20'(t_r));
  assign t2s = signed'(20'(t2_r));
  assign t3s = signed'(20'(t3_r));
  assign h00 = 20'sd2 * t3s - 20'sd3 * t2s + 20'sd65536;
  assign h01 = 20'sd3 * t2s - 20'sd2 * t3s;
  assign h10 = t3s - 20'sd2 * t2s + t1s;
  assign h11 = t3s - t2s;

  assign mj = step_r - ST_MUL0;
  assign aj = step_r - ST_ACC0;

  always_comb begin
    op_a = signed'({1'b0, t_r});
    op_b = signed'(32'(t_r));
    if (step_r == 5'd1) begin
      op_a = signed'({1'b0, prod[32:16]});
    end else if (step_r >= ST_MUL0) begin
      op_a = h_r[mj[1:0]];
      unique case (mj[1:0])
        2'd0:    op_b = axis_of(p_r[1], mj[3:2]);
        2'd1:    op_b = axis_of(p_r[2], mj[3:2]);
        2'd2:    op_b = m0_r[mj[3:2]];
        default: op_b = m1_r[mj[3:2]];
      endcase
    end
  end

  assign mac_ctl.acc_en  = (state_r == S_CALC) && (step_r >= ST_ACC0) && (step_r <= ST_ACC_L);
  assign mac_ctl.acc_clr = (aj[1:0] == 2'd0);

  crse_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .ctl  (mac_ctl),
    .prod (prod),
    .acc  (acc)
  );

  // divide by 65536 toward zero, then saturate
  assign acc_adj = acc + (acc[crse_pkg::ACC_W-1] ? crse_pkg::ACC_W'(65535) : '0);
  assign quo     = acc_adj >>> 16;
  always_comb begin
    if (quo > crse_pkg::ACC_W'(64'sd2147483647)) begin
      fin = 32'sh7fffffff;
    end else if (quo < -crse_pkg::ACC_W'(64'sd2147483648)) begin
      fin = 32'sh80000000;
    end else begin
      fin = quo[31:0];
    end
  end

  assign first_pt = (idx_r == '0);
  assign last_seg = (idx_r + WW'(2) == n_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= idx_w;
      n_r   <= n_w;
      t_r   <= in_data.frac;
    end
    rd_vld_r  <= (state_r == S_RD);
    rd_slot_r <= cnt_r;
    if (rd_vld_r) begin
      p_r[rd_slot_r] <= rdata;
    end
    if (state_r == S_CALC) begin
      if (step_r == 5'd0) begin
        closed_r <= (p_r[4] == p_r[5]);
      end
      if (step_r == 5'd1) begin
        t2_r <= prod[32:16];
      end
      if (step_r == 5'd2) begin
        t3_r <= prod[32:16];
        for (int a = 0; a < 3; a++) begin
          if (first_pt) begin
            m0_r[a] <= closed_r ? half_diff(axis_of(p_r[6], 2'(a)), axis_of(p_r[7], 2'(a)))
                                : half_diff(axis_of(p_r[2], 2'(a)), axis_of(p_r[1], 2'(a)));
          end else begin
            m0_r[a] <= half_diff(axis_of(p_r[2], 2'(a)), axis_of(p_r[0], 2'(a)));
          end
          if (last_seg) begin
            m1_r[a] <= closed_r ? half_diff(axis_of(p_r[6], 2'(a)), axis_of(p_r[7], 2'(a)))
                                : half_diff(axis_of(p_r[2], 2'(a)), axis_of(p_r[1], 2'(a)));
          end else begin
            m1_r[a] <= half_diff(axis_of(p_r[3], 2'(a)), axis_of(p_r[1], 2'(a)));
          end
        end
      end
      if (step_r == 5'd3) begin
        h_r[0] <= h00[17:0];
        h_r[1] <= h01[17:0];
        h_r[2] <= h10[17:0];
        h_r[3] <= h11[17:0];
      end
      if (step_r == ST_X) begin
        px_r <= fin;
      end
      if (step_r == ST_Y) begin
        py_r <= fin;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:  out_valid_nxt = accept && ((in_data.action == crse_pkg::ACT_WRITE)
                                          || (idx_w >= n_w));
      S_RAW:   out_valid_nxt = 1'b1;
      S_CALC:  out_valid_nxt = (step_r == ST_LAST);
      default: out_valid_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      step_r       <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
      num_points_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        num_points_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.action == crse_pkg::ACT_WRITE) begin
              out_data_r <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                              status: (idx_w >= WW'(MAX_POINTS)) ? crse_pkg::ST_ERR
                                                                  : crse_pkg::ST_OK};
            end else if (idx_w >= n_w) begin
              out_data_r <= '{pos_x: '0, pos_y: '0, pos_z: '0,
                              status: crse_pkg::ST_ERR};
            end else if ((idx_w + WW'(1) == n_w) || (in_data.frac == '0)
                         || in_data.frac[16]) begin
              state_r <= S_RAW;
            end else begin
              state_r <= S_RD;
              cnt_r   <= '0;
            end
          end
        end
        S_RAW: begin
          out_data_r  <= '{pos_x: rdata.x, pos_y: rdata.y, pos_z: rdata.z,
                           status: crse_pkg::ST_OK};
          state_r     <= S_IDLE;
        end
        S_RD: begin
          cnt_r <= cnt_r + SW'(1);
          if (cnt_r == SW'(NUM_SLOTS - 1)) begin
            state_r <= S_CALC;
            step_r  <= '0;
          end
        end
        S_CALC: begin
          step_r <= step_r + 5'd1;
          if (step_r == ST_LAST) begin
            out_data_r  <= '{pos_x: px_r, pos_y: py_r, pos_z: fin,
                             status: crse_pkg::ST_OK};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hdl/crse_checker.sv
// port-level checks for the catmull-rom spline evaluator, bound to the top level
// depends on crse_pkg for codes and item types
module crse_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input crse_pkg::in_item_t  in_data,
  input logic                out_valid,
  input crse_pkg::out_item_t out_data
);

  // a write item is answered in the very next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.action == crse_pkg::ACT_WRITE) |=> out_valid)
    else $error("write item gave no result in the next cycle");

  // one item at a time: a result only comes once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // an error result carries zero position
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == crse_pkg::ST_ERR) |->
      (out_data.pos_x == '0) && (out_data.pos_y == '0) && (out_data.pos_z == '0))
    else $error("error result with nonzero position");

  // busy only rises after an accepted item
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

endmodule

bind catmull_rom_spline_evaluator_unit crse_checker u_crse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
